>>> rtl/card_stack_shuffler_unit_macros.svh
// Assertion macros for the card stack shuffler unit.
`ifndef CARD_STACK_SHUFFLER_UNIT_MACROS_SVH
`define CARD_STACK_SHUFFLER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define CSSU_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CSSU_ASSERT_IMPLY(lbl, ante, cons, msg)
`define CSSU_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/cssu_pkg.sv
// Shared types and constants of the card stack shuffler unit.
package cssu_pkg;

  localparam int COLOR_W  = 3;
  localparam int NUMBER_W = 4;
  localparam int CARD_W   = COLOR_W + NUMBER_W;
  localparam int RAND_W   = 15;
  localparam int HELD_W   = 8;

  typedef enum logic [1:0] {
    MODE_PUSH  = 2'd0,
    MODE_POP   = 2'd1,
    MODE_BEGIN = 2'd2,
    MODE_STEP  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_DONE  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_POP_WAIT,
    S_STEP_CHK,
    S_DIV,
    S_RD_CUR,
    S_RD_POS,
    S_WR_CUR,
    S_WR_POS,
    S_RESULT
  } state_t;

  typedef struct packed {
    mode_t                mode;
    logic [COLOR_W-1:0]   in_color;
    logic [NUMBER_W-1:0]  in_number;
    logic [RAND_W-1:0]    random_word;
  } in_word_t;

  typedef struct packed {
    logic [COLOR_W-1:0]   out_color;
    logic [NUMBER_W-1:0]  out_number;
    status_t              status;
    logic [HELD_W-1:0]    held_count;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic    load_item;
    logic    push_wr;
    logic    pop_rd;
    logic    begin_cur;
    logic    clamp;
    logic    div_start;
    logic    div_step;
    logic    rd_cur;
    logic    rd_pos;
    logic    wr_cur;
    logic    wr_pos;
    logic    cap_card;
    logic    set_stat;
    status_t stat;
    logic    res_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    mode_t mode;
    logic  full;
    logic  empty;
    logic  cur_zero;
    logic  cur_one;
    logic  div_last;
    logic  out_free;
  } sts_t;

endpackage

>>> rtl/cssu_ctrl.sv
// Sequencing state machine of the card stack shuffler unit.
module cssu_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cssu_pkg::sts_t sts,
  output cssu_pkg::cmd_t cmd
);
  import cssu_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.mode)
          MODE_PUSH: begin
            cmd.set_stat = 1'b1;
            if (sts.full) begin
              cmd.stat = ST_FULL;
            end else begin
              cmd.push_wr = 1'b1;
              cmd.stat    = ST_OK;
            end
            state_nxt = S_RESULT;
          end
          MODE_POP: begin
            if (sts.empty) begin
              cmd.set_stat = 1'b1;
              cmd.stat     = ST_EMPTY;
              state_nxt    = S_RESULT;
            end else begin
              cmd.pop_rd = 1'b1;
              state_nxt  = S_POP_WAIT;
            end
          end
          MODE_BEGIN: begin
            cmd.begin_cur = 1'b1;
            cmd.set_stat  = 1'b1;
            cmd.stat      = ST_OK;
            state_nxt     = S_RESULT;
          end
          MODE_STEP: begin
            cmd.clamp = 1'b1;
            state_nxt = S_STEP_CHK;
          end
        endcase
      end
      S_POP_WAIT: begin
        cmd.cap_card = 1'b1;
        cmd.set_stat = 1'b1;
        cmd.stat     = ST_OK;
        state_nxt    = S_RESULT;
      end
      S_STEP_CHK: begin
        if (sts.cur_zero) begin
          cmd.set_stat = 1'b1;
          cmd.stat     = ST_DONE;
          state_nxt    = S_RESULT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_RD_CUR;
        end
      end
      S_RD_CUR: begin
        cmd.rd_cur = 1'b1;
        state_nxt  = S_RD_POS;
      end
      S_RD_POS: begin
        cmd.rd_pos = 1'b1;
        state_nxt  = S_WR_CUR;
      end
      S_WR_CUR: begin
        cmd.wr_cur = 1'b1;
        state_nxt  = S_WR_POS;
      end
      S_WR_POS: begin
        cmd.wr_pos   = 1'b1;
        cmd.set_stat = 1'b1;
        cmd.stat     = sts.cur_one ? ST_DONE : ST_OK;
        state_nxt    = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/cssu_dp.sv
// Datapath of the card stack shuffler unit: card memory, count, cursor, remainder unit.
module cssu_dp #(
  parameter int DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cssu_pkg::in_word_t in_word,
  input  cssu_pkg::cmd_t     cmd,
  output cssu_pkg::sts_t     sts,
  output logic               out_valid,
  input  logic               out_stall,
  output cssu_pkg::out_word_t out_word
);
  import cssu_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int RW  = AW + 2;
  localparam int DCW = $clog2(RAND_W + 1);

  logic [CARD_W-1:0] mem [DEPTH];

  in_word_t          item_r;
  logic [CW-1:0]     count_r;
  logic [AW-1:0]     cursor_r;
  logic [RW-1:0]     rem_r;
  logic [RAND_W-1:0] rnd_sh_r;
  logic [DCW-1:0]    bit_cnt_r;
  logic [CARD_W-1:0] rd_data_r;
  logic [CARD_W-1:0] tmp_r;
  logic [CARD_W-1:0] card_out_r;
  status_t           stat_r;
  out_word_t         out_word_r;
  logic              out_valid_r;

  logic [CW-1:0]        count_m1;
  logic [AW-1:0]        top_idx;
  logic [AW-1:0]        clamp_val;
  logic [AW:0]          divisor;
  logic [RW-1:0]        trial;
  logic [AW-1:0]        pos;
  logic [CARD_W-1:0]    card_in;
  logic                 wr_en, rd_en;
  logic [AW-1:0]        wr_addr, rd_addr;
  logic [CARD_W-1:0]    wr_data;
  logic [CW+HELD_W-1:0] count_wide;
  logic                 out_free;

  assign count_m1 = count_r - CW'(1);
  assign top_idx  = count_m1[AW-1:0];
  assign pos      = rem_r[AW-1:0];
  assign card_in  = {item_r.in_color, item_r.in_number};
  assign divisor  = (AW+1)'(cursor_r) + (AW+1)'(1);
  assign trial    = {rem_r[RW-2:0], rnd_sh_r[RAND_W-1]};

  // cursor left above the top by pops is pulled back to the top card
  always_comb begin
    if (count_r == '0) begin
      clamp_val = '0;
    end else if ((CW+1)'(cursor_r) >= (CW+1)'(count_r)) begin
      clamp_val = top_idx;
    end else begin
      clamp_val = cursor_r;
    end
  end

  // single write port, single registered read port
  always_comb begin
    wr_en   = cmd.push_wr | cmd.wr_cur | cmd.wr_pos;
    wr_addr = count_r[AW-1:0];
    wr_data = card_in;
    if (cmd.wr_cur) begin
      wr_addr = cursor_r;
      wr_data = rd_data_r;
    end else if (cmd.wr_pos) begin
      wr_addr = pos;
      wr_data = tmp_r;
    end
    rd_en   = cmd.pop_rd | cmd.rd_cur | cmd.rd_pos;
    rd_addr = top_idx;
    if (cmd.rd_cur) begin
      rd_addr = cursor_r;
    end else if (cmd.rd_pos) begin
      rd_addr = pos;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r     <= in_word;
      card_out_r <= '0;
    end
    if (cmd.cap_card) begin
      card_out_r <= rd_data_r;
    end
    if (cmd.set_stat) begin
      stat_r <= cmd.stat;
    end
    if (cmd.rd_pos) begin
      tmp_r <= rd_data_r;
    end
    if (cmd.div_start) begin
      rem_r     <= '0;
      rnd_sh_r  <= item_r.random_word;
      bit_cnt_r <= DCW'(RAND_W);
    end else if (cmd.div_step) begin
      rem_r     <= (trial >= RW'(divisor)) ? (trial - RW'(divisor)) : trial;
      rnd_sh_r  <= {rnd_sh_r[RAND_W-2:0], 1'b0};
      bit_cnt_r <= bit_cnt_r - DCW'(1);
    end
    if (cmd.res_load) begin
      out_word_r.out_color  <= card_out_r[CARD_W-1:NUMBER_W];
      out_word_r.out_number <= card_out_r[NUMBER_W-1:0];
      out_word_r.status     <= stat_r;
      out_word_r.held_count <= count_wide[HELD_W-1:0];
    end
  end

  assign count_wide = (CW+HELD_W)'(count_r);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cursor_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.push_wr) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.pop_rd) begin
        count_r <= count_m1;
      end
      if (cmd.begin_cur) begin
        cursor_r <= (count_r == '0) ? '0 : top_idx;
      end else if (cmd.clamp) begin
        cursor_r <= clamp_val;
      end else if (cmd.wr_pos) begin
        cursor_r <= cursor_r - AW'(1);
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  assign sts.mode     = item_r.mode;
  assign sts.full     = (count_r == CW'(DEPTH));
  assign sts.empty    = (count_r == '0);
  assign sts.cur_zero = (cursor_r == '0);
  assign sts.cur_one  = (cursor_r == AW'(1));
  assign sts.div_last = (bit_cnt_r == DCW'(1));
  assign sts.out_free = out_free;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> rtl/card_stack_shuffler_unit.sv
// Top level of the card stack shuffler unit: a card stack with in-place shuffle.
//
//  channel | ports                        | direction | word
//  --------+------------------------------+-----------+---------------------------
//  in      | in_valid, in_stall, in_word  | to unit   | mode, card, random word
//  out     | out_valid, out_stall, out_word | from unit | card, status, held count
//
// Flow: one word at a time. Push and begin pass decode and result, pop adds
//   a wait for the registered memory read, a step at cursor zero adds the
//   cursor check, and a swapping step adds the remainder unit (one random bit
//   per cycle) and four accesses to the card memory (one write, one read port).
// Reset: rst_n synchronous, clears count, cursor, output valid and the
//   controller; the card memory is not cleared.
// Stalls: out_stall holds the result register; the next word is still taken
//   and worked on, and waits to deliver until the register frees.
module card_stack_shuffler_unit #(
  parameter int DEPTH = 128
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cssu_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output cssu_pkg::out_word_t out_word
);
  import cssu_pkg::*;

`include "card_stack_shuffler_unit_macros.svh"

  cmd_t cmd;  // controller commands
  sts_t sts;  // datapath status

  // sequencer: decodes the word's mode, walks step and pop sequences
  cssu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage, remainder unit and result register
  cssu_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // an accepted word keeps the input closed for at least the next cycle
  `CSSU_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open after accept")

  // a result is never loaded over one that has not been taken
  `CSSU_ASSERT_IMPLY(a_no_overwrite, cmd.res_load, sts.out_free, "result register overwritten")

  // a full stack never takes another card
  `CSSU_ASSERT_IMPLY(a_no_push_full, sts.full, !cmd.push_wr, "push into full stack")

endmodule

>>> tb/card_stack_shuffler_unit_tb.sv
// Self-checking testbench for the card stack shuffler unit.
`timescale 1ns / 1ps

module card_stack_shuffler_unit_tb;
  import cssu_pkg::*;

  localparam int STACK_DEPTH  = 128;
  localparam int RANDOM_WORDS = 1440;
  localparam int LONG_HOLD    = 300;

  // Directed plan row. reps repeats the row; shake_fields draws fresh card
  // and random fields for every repeat. pinned rows carry a hand-typed result.
  typedef struct {
    mode_t       mode;
    logic [2:0]  color;
    logic [3:0]  number;
    logic [14:0] rnd;
    int          reps;
    bit          shake_fields;
    bit          pinned;
    out_word_t   want;
  } plan_row_t;

  typedef struct packed {
    logic      on;
    out_word_t w;
  } pin_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  card_stack_shuffler_unit #(
    .DEPTH(STACK_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the card stack: store, count and shuffle cursor.
  // ---------------------------------------------------------------------------
  logic [6:0] deck_mem [STACK_DEPTH];
  int         deck_held;
  int         deck_cursor;

  out_word_t  pending_results[$];   // predicted results, oldest first
  pin_t       pinned_results[$];    // hand-typed overrides for directed rows
  plan_row_t  plan[$];

  int failures;
  int results_seen;
  int full_pushes;
  int empty_pops;
  int swaps_done;
  int shuffles_done;
  int words_sent;
  int gen_count;      // stimulus-side estimate of cards held
  int burst_left;
  bit hold_request;

  out_word_t guess;
  out_word_t want;
  pin_t      pin;

  // Work out the result word for one accepted input word and advance the
  // shadow state.
  function automatic out_word_t predict_card_result(in_word_t w);
    out_word_t  r;
    logic [6:0] tmp;
    int         pos;
    r        = '0;
    r.status = ST_OK;
    case (w.mode)
      MODE_PUSH: begin
        if (deck_held >= STACK_DEPTH) begin
          r.status = ST_FULL;
          full_pushes++;
        end else begin
          deck_mem[deck_held] = {w.in_color, w.in_number};
          deck_held++;
        end
      end
      MODE_POP: begin
        if (deck_held == 0) begin
          r.status = ST_EMPTY;
          empty_pops++;
        end else begin
          deck_held--;
          {r.out_color, r.out_number} = deck_mem[deck_held];
        end
      end
      MODE_BEGIN: begin
        deck_cursor = (deck_held == 0) ? 0 : deck_held - 1;
      end
      default: begin
        // pops may have left the cursor above the top card
        if (deck_held == 0) begin
          deck_cursor = 0;
        end else if (deck_cursor >= deck_held) begin
          deck_cursor = deck_held - 1;
        end
        if (deck_cursor == 0) begin
          r.status = ST_DONE;
        end else begin
          pos                   = int'(w.random_word) % (deck_cursor + 1);
          tmp                   = deck_mem[deck_cursor];
          deck_mem[deck_cursor] = deck_mem[pos];
          deck_mem[pos]         = tmp;
          deck_cursor--;
          swaps_done++;
          if (deck_cursor == 0) begin
            r.status = ST_DONE;
            shuffles_done++;
          end
        end
      end
    endcase
    r.held_count = deck_held[7:0];
    return r;
  endfunction

  function automatic out_word_t card_result(logic [2:0] c, logic [3:0] n, status_t s,
                                            int held);
    out_word_t r;
    r.out_color  = c;
    r.out_number = n;
    r.status     = s;
    r.held_count = held[7:0];
    return r;
  endfunction

  function automatic in_word_t random_item(mode_t m);
    in_word_t w;
    w.mode        = m;
    w.in_color    = 3'($urandom_range(0, 4));
    w.in_number   = 4'($urandom_range(0, 14));
    w.random_word = 15'($urandom_range(0, 32767));
    return w;
  endfunction

  task automatic check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      failures++;
    end
  endtask

  task automatic add_row(mode_t m, int c, int n, int rnd, int reps, bit shake, bit pinned,
                         out_word_t w);
    plan_row_t row;
    row.mode         = m;
    row.color        = 3'(c);
    row.number       = 4'(n);
    row.rnd          = 15'(rnd);
    row.reps         = reps;
    row.shake_fields = shake;
    row.pinned       = pinned;
    row.want         = w;
    plan.push_back(row);
  endtask

  // Offer one word and wait for it to be taken. The sender runs in bursts;
  // a gap, when one is drawn, drops valid before the next burst.
  task automatic put_word(in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    burst_left--;
    words_sent++;
    if (w.mode == MODE_PUSH && gen_count < STACK_DEPTH) gen_count++;
    if (w.mode == MODE_POP && gen_count > 0) gen_count--;
  endtask

  // Hold the sender until every predicted result has been delivered.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: the stall rate is redrawn among none, 25, 50 and 85 percent; one
  // long hold on request lets the unit fill up and stall its input.
  // ---------------------------------------------------------------------------
  int  stall_pct = 0;
  int  rx_cycle = 0;
  int  hold_left = 0;
  bit  hold_used = 1'b0;

  always @(posedge clk) begin
    rx_cycle++;
    if (rx_cycle % 128 == 0) begin
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 25;
        2: stall_pct = 50;
        default: stall_pct = 85;
      endcase
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_request && !hold_used) begin
      hold_used = 1'b1;
      hold_left = LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input word, compare every accepted
  // result word with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        guess = predict_card_result(in_word);
        if (pinned_results.size() != 0) begin
          pin = pinned_results.pop_front();
          if (pin.on) guess = pin.w;
        end
        pending_results.push_back(guess);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result word with nothing pending: %h", out_word);
          failures++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_color", want.out_color, out_word.out_color);
          check_field("out_number", want.out_number, out_word.out_number);
          check_field("status", want.status, out_word.status);
          check_field("held_count", want.held_count, out_word.held_count);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    in_word_t w;
    pin_t     p;
    int       directed_words;
    int       pick;
    int       n;
    bit       drained;

    failures      = 0;
    results_seen  = 0;
    full_pushes   = 0;
    empty_pops    = 0;
    swaps_done    = 0;
    shuffles_done = 0;
    words_sent    = 0;
    gen_count     = 0;
    burst_left    = 0;
    hold_request  = 1'b0;
    drained       = 1'b0;
    deck_held     = 0;
    deck_cursor   = 0;

    // Directed plan: empty stack corners, small shuffle with clamp, then a
    // full stack, rejected push, full shuffle and full drain.
    add_row(MODE_POP,   0, 0,     0,   1, 0, 1, card_result(0, 0, ST_EMPTY, 0));
    add_row(MODE_STEP,  0, 0, 32767,   1, 0, 1, card_result(0, 0, ST_DONE, 0));
    add_row(MODE_BEGIN, 0, 0,     0,   1, 0, 1, card_result(0, 0, ST_OK, 0));
    add_row(MODE_PUSH,  4, 14,    0,   1, 0, 1, card_result(0, 0, ST_OK, 1));
    add_row(MODE_PUSH,  0, 0, 32767,   1, 0, 1, card_result(0, 0, ST_OK, 2));
    add_row(MODE_POP,   0, 0,     0,   1, 0, 1, card_result(0, 0, ST_OK, 1));
    add_row(MODE_POP,   0, 0,     0,   1, 0, 1, card_result(4, 14, ST_OK, 0));
    add_row(MODE_PUSH,  1, 5,     0,   1, 0, 1, card_result(0, 0, ST_OK, 1));
    add_row(MODE_PUSH,  2, 9,     0,   1, 0, 1, card_result(0, 0, ST_OK, 2));
    add_row(MODE_PUSH,  3, 7,     0,   1, 0, 1, card_result(0, 0, ST_OK, 3));
    add_row(MODE_BEGIN, 0, 0,     0,   1, 0, 1, card_result(0, 0, ST_OK, 3));
    add_row(MODE_STEP,  0, 0, 32767,   1, 0, 0, '0);
    add_row(MODE_STEP,  0, 0,     0,   1, 0, 1, card_result(0, 0, ST_DONE, 3));
    // cursor already at zero
    add_row(MODE_STEP,  0, 0,   123,   1, 0, 1, card_result(0, 0, ST_DONE, 3));
    add_row(MODE_BEGIN, 0, 0,     0,   1, 0, 1, card_result(0, 0, ST_OK, 3));
    add_row(MODE_POP,   0, 0,     0,   1, 0, 0, '0);
    add_row(MODE_POP,   0, 0,     0,   1, 0, 0, '0);
    // cursor left above the top card: clamps to zero
    add_row(MODE_STEP,  0, 0,  1000,   1, 0, 1, card_result(0, 0, ST_DONE, 1));
    add_row(MODE_POP,   0, 0,     0,   1, 0, 0, '0);
    add_row(MODE_PUSH,  0, 0,     0, STACK_DEPTH, 1, 0, '0);
    add_row(MODE_PUSH,  4, 14,    0,   1, 0, 1, card_result(0, 0, ST_FULL, STACK_DEPTH));
    add_row(MODE_BEGIN, 0, 0,     0,   1, 0, 1, card_result(0, 0, ST_OK, STACK_DEPTH));
    add_row(MODE_STEP,  0, 0,     0, STACK_DEPTH - 1, 1, 0, '0);
    add_row(MODE_STEP,  0, 0,     0,   1, 0, 1, card_result(0, 0, ST_DONE, STACK_DEPTH));
    add_row(MODE_POP,   0, 0,     0, STACK_DEPTH, 0, 0, '0);
    add_row(MODE_POP,   0, 0,     0,   1, 0, 1, card_result(0, 0, ST_EMPTY, 0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        if (plan[i].shake_fields) begin
          w = random_item(plan[i].mode);
        end else begin
          w.mode        = plan[i].mode;
          w.in_color    = plan[i].color;
          w.in_number   = plan[i].number;
          w.random_word = plan[i].rnd;
        end
        p.on = plan[i].pinned;
        p.w  = plan[i].want;
        pinned_results.push_back(p);
        put_word(w);
      end
    end
    directed_words = words_sent;

    // Long receiver hold while the sender keeps offering words.
    hold_request = 1'b1;

    // Random part: mostly well-formed episodes (runs of pushes and pops,
    // full and partial shuffles, fills and drains) plus some noise.
    while (words_sent < directed_words + RANDOM_WORDS) begin
      if (!drained && words_sent >= directed_words + RANDOM_WORDS / 2) begin
        drain_results();
        drained = 1'b1;
      end
      pick = $urandom_range(0, 15);
      if (pick <= 3) begin
        n = $urandom_range(1, 24);
        repeat (n) put_word(random_item(MODE_PUSH));
      end else if (pick == 4) begin
        // fill past the top to hit the rejected push
        n = STACK_DEPTH - gen_count + $urandom_range(1, 3);
        repeat (n) put_word(random_item(MODE_PUSH));
      end else if (pick <= 6) begin
        n = $urandom_range(1, 24);
        repeat (n) put_word(random_item(MODE_POP));
      end else if (pick <= 10) begin
        // complete shuffle, sometimes stepping past the end
        put_word(random_item(MODE_BEGIN));
        n = gen_count + $urandom_range(0, 2);
        repeat (n) put_word(random_item(MODE_STEP));
      end else if (pick == 11) begin
        // partial shuffle, pops under the cursor, then more steps
        put_word(random_item(MODE_BEGIN));
        n = $urandom_range(0, gen_count / 2);
        repeat (n) put_word(random_item(MODE_STEP));
        n = $urandom_range(1, 6);
        repeat (n) put_word(random_item(MODE_POP));
        n = $urandom_range(1, 6);
        repeat (n) put_word(random_item(MODE_STEP));
      end else if (pick == 12) begin
        n = gen_count + $urandom_range(1, 2);
        repeat (n) put_word(random_item(MODE_POP));
      end else begin
        n = $urandom_range(1, 8);
        repeat (n) put_word(random_item(mode_t'($urandom_range(0, 3))));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Sent %0d words (%0d directed), checked %0d result words.",
             words_sent, directed_words, results_seen);
    $display("Saw %0d rejected pushes, %0d empty pops, %0d swaps, %0d finished shuffles.",
             full_pushes, empty_pops, swaps_done, shuffles_done);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog, well above the slowest legal run.
  initial begin
    #8_000_000;
    $display("timeout with %0d results pending", pending_results.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
